/* rtl/brb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brb_pkg: shared definitions for the byte ring buffer
// Operation codes, default depth and the status record passed from the
// index controller to the output stage.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int BRB_DEPTH = 256;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic       read_ok;
        logic [7:0] data_count;
        logic [7:0] space_count;
        logic [7:0] overflow_count;
    } brb_status_t;

endpackage
// ----------------------------------------------------------------------------
`default_nettype wire

/* rtl/brb_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brb_if: request, response and configuration channels
// Valid/ready channels of the byte ring buffer.
// ----------------------------------------------------------------------------
interface brb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] write_data;
    logic       call_last;

    modport source (output valid, output operation, output write_data,
                    output call_last, input ready);
    modport sink   (input valid, input operation, input write_data,
                    input call_last, output ready);
endinterface

interface brb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       read_ok;
    logic [7:0] data_count;
    logic [7:0] space_count;
    logic [7:0] overflow_count;

    modport source (output valid, output read_data, output read_ok,
                    output data_count, output space_count,
                    output overflow_count, input ready);
    modport sink   (input valid, input read_data, input read_ok,
                    input data_count, input space_count,
                    input overflow_count, output ready);
endinterface

interface brb_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] size_in_use;

    modport source (output valid, output size_in_use, input ready);
    modport sink   (input valid, input size_in_use, output ready);
endinterface
// ----------------------------------------------------------------------------
`default_nettype wire

/* rtl/byte_ring_buffer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer: byte circular FIFO with overwrite on full
// Write, read or clear requests; one response per request.
// ----------------------------------------------------------------------------
// Usage: the buffer takes one request per clock and answers each with one
// response: acceptance updates the indices, accesses the byte memory (one
// write port, one registered read port) and fills the in-flight stage, which
// moves the result into the output register once that is free. A stalled
// output holds the request channel off only once the in-flight stage and the
// output register are both occupied. Capacity is size_in_use minus one bytes
// (size clamped to 2..DEPTH). A write into a full buffer drops the oldest
// byte; overwrites are counted per write call and latched into
// overflow_count at the write marked call_last if nonzero. Writing size_in_use
// empties the buffer like a clear; do so only while no request is in flight.
// The memory needs no clearing after reset, so requests are taken at once.
// ----------------------------------------------------------------------------
module byte_ring_buffer #(
    parameter int DEPTH = brb_pkg::BRB_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input wire logic  clk,
    input wire logic  rst_n,
    brb_in_if.sink    in_chan,
    brb_out_if.source out_chan,
    brb_cfg_if.sink   cfg_chan
);

    logic                 in_fire;
    logic                 out_free;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [7:0]           mem_wdata, mem_rdata;
    brb_pkg::brb_status_t status;

    // in-flight stage: waits for the memory read data
    logic                 stage_valid_reg, stage_valid_next;
    brb_pkg::brb_status_t stage_status_reg;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_rdata_reg;
    brb_pkg::brb_status_t out_status_reg;

    assign out_free       = !out_valid_reg || out_chan.ready;
    assign in_chan.ready  = !stage_valid_reg || out_free;
    assign in_fire        = in_chan.valid && in_chan.ready;
    assign cfg_chan.ready = 1'b1;

    brb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_fire),
        .operation  (in_chan.operation),
        .write_data (in_chan.write_data),
        .call_last  (in_chan.call_last),
        .cfg_we     (cfg_chan.valid),
        .cfg_size   (cfg_chan.size_in_use),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .status     (status)
    );

    brb_mem #(.DEPTH(DEPTH)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        out_valid_next   = out_valid_reg;
        if (out_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (stage_valid_reg && out_free)
        begin
            out_valid_next   = 1'b1;
            stage_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            stage_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_status_reg <= status;
        end
        if (stage_valid_reg && out_free)
        begin
            out_status_reg <= stage_status_reg;
            out_rdata_reg  <= stage_status_reg.read_ok ? mem_rdata : 8'd0;
        end
    end

    assign out_chan.valid          = out_valid_reg;
    assign out_chan.read_data      = out_rdata_reg;
    assign out_chan.read_ok        = out_status_reg.read_ok;
    assign out_chan.data_count     = out_status_reg.data_count;
    assign out_chan.space_count    = out_status_reg.space_count;
    assign out_chan.overflow_count = out_status_reg.overflow_count;

    // memory reads only on behalf of an accepted read request
    a_read_on_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        mem_re |-> in_fire
    ) else $error("memory read without accepted request");

    // an accepted request always occupies the stage next cycle
    a_stage_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_fire |=> stage_valid_reg
    ) else $error("accepted request lost from stage");

    // a blocked stage keeps its status
    a_stage_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !out_free && !in_fire) |=>
            (stage_valid_reg && $stable(stage_status_reg))
    ) else $error("stalled stage changed");

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

/* rtl/brb_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brb_mem: byte storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brb_mem #(
    parameter int DEPTH = brb_pkg::BRB_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

/* rtl/brb_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ctrl: index and overflow controller
// Holds read/write indices, size and overwrite counters; drives the
// storage ports and computes the status of each accepted request.
// ----------------------------------------------------------------------------
module brb_ctrl #(
    parameter int DEPTH = brb_pkg::BRB_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW   = AW + 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [1:0]         operation,
    input  wire logic [7:0]         write_data,
    input  wire logic               call_last,
    input  wire logic               cfg_we,
    input  wire logic [8:0]         cfg_size,
    output logic                    mem_we,
    output logic      [AW-1:0]      mem_waddr,
    output logic      [7:0]         mem_wdata,
    output logic                    mem_re,
    output logic      [AW-1:0]      mem_raddr,
    output brb_pkg::brb_status_t    status
);

    function automatic logic [NW-1:0] clamp_size(input logic [8:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 < 32'd2)
            v32 = 32'd2;
        else if (v32 > 32'(DEPTH))
            v32 = 32'(DEPTH);
        return v32[NW-1:0];
    endfunction

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] idx,
                                           input logic [NW-1:0] s);
        logic [NW-1:0] n;
        n = NW'(idx) + NW'(1);
        return (n >= s) ? AW'(0) : n[AW-1:0];
    endfunction

    function automatic logic [7:0] sat8(input logic [NW-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        return (v32 > 32'd255) ? 8'hFF : v32[7:0];
    endfunction

    logic [NW-1:0] size_reg;
    logic [AW-1:0] widx_reg, widx_next;
    logic [AW-1:0] ridx_reg, ridx_next;
    logic [7:0]    ovf_reg, ovf_next;
    logic [7:0]    cnt_reg, cnt_next;

    logic [AW-1:0] wi, ri, w1;
    logic [7:0]    cnt_inc;
    logic          not_empty;
    logic [NW-1:0] held;

    // indices are always inside the size; guard kept for safety
    assign wi = (NW'(widx_reg) >= size_reg) ? AW'(0) : widx_reg;
    assign ri = (NW'(ridx_reg) >= size_reg) ? AW'(0) : ridx_reg;
    assign w1 = bump(wi, size_reg);
    assign not_empty = (ri != wi);
    assign cnt_inc = (cnt_reg == 8'hFF) ? cnt_reg : cnt_reg + 8'd1;

    always_comb
    begin
        widx_next = wi;
        ridx_next = ri;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        case (operation)
            brb_pkg::OP_WRITE:
            begin
                widx_next = w1;
                if (w1 == ri)
                begin
                    // full: drop oldest byte
                    ridx_next = bump(ri, size_reg);
                    cnt_next  = cnt_inc;
                end
                if (call_last)
                begin
                    if (cnt_next != 8'd0)
                    begin
                        ovf_next = cnt_next;
                    end
                    cnt_next = 8'd0;
                end
            end
            brb_pkg::OP_READ:
            begin
                if (not_empty)
                begin
                    ridx_next = bump(ri, size_reg);
                end
            end
            brb_pkg::OP_CLEAR:
            begin
                widx_next = '0;
                ridx_next = '0;
                ovf_next  = 8'd0;
                cnt_next  = 8'd0;
            end
            default:
            begin
                widx_next = wi;
            end
        endcase
    end

    assign held = (NW'(widx_next) >= NW'(ridx_next))
                ? NW'(widx_next) - NW'(ridx_next)
                : size_reg + NW'(widx_next) - NW'(ridx_next);

    always_comb
    begin
        status.read_ok        = (operation == brb_pkg::OP_READ) && not_empty;
        status.data_count     = sat8(held);
        status.space_count    = sat8(size_reg - NW'(1) - held);
        status.overflow_count = ovf_next;
    end

    assign mem_we    = accept && (operation == brb_pkg::OP_WRITE);
    assign mem_waddr = wi;
    assign mem_wdata = write_data;
    assign mem_re    = accept && (operation == brb_pkg::OP_READ) && not_empty;
    assign mem_raddr = ri;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= clamp_size(9'd256);
            widx_reg <= '0;
            ridx_reg <= '0;
            ovf_reg  <= 8'd0;
            cnt_reg  <= 8'd0;
        end
        else if (cfg_we)
        begin
            // new size restarts the buffer
            size_reg <= clamp_size(cfg_size);
            widx_reg <= '0;
            ridx_reg <= '0;
            ovf_reg  <= 8'd0;
            cnt_reg  <= 8'd0;
        end
        else if (accept)
        begin
            widx_reg <= widx_next;
            ridx_reg <= ridx_next;
            ovf_reg  <= ovf_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire
